// ----- sv/adjacency_matrix_degree_store_defines.svh -----
// assertion macros for the adjacency matrix degree store
`ifndef ADJACENCY_MATRIX_DEGREE_STORE_DEFINES_SVH
`define ADJACENCY_MATRIX_DEGREE_STORE_DEFINES_SVH

// same-cycle implication
`define AMDS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AMDS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/amds_pkg.sv -----
// ----------------------------------------------------------------------------
// amds_pkg
// types and constants shared by the adjacency matrix degree store
// ----------------------------------------------------------------------------
`default_nettype none

package amds_pkg;

    localparam int MAX_VERTICES = 64;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_VERTEX_COUNT = 3'd0;
    localparam logic [6:0] VERTEX_COUNT_RESET = 7'd64;

    typedef enum logic [2:0] {
        MODE_INSERT = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_TEST   = 3'd2,
        MODE_NEXT   = 3'd3,
        MODE_COUNT  = 3'd4,
        MODE_MAX    = 3'd5,
        MODE_MIN    = 3'd6,
        MODE_UNUSED = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_REMOVE,
        OP_TEST,
        OP_NEXT,
        OP_COUNT,
        OP_MAX,
        OP_MIN
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WRITE_B,
        ST_SCAN_ROW,
        ST_SCAN_DEG
    } state_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [5:0] vertex_a;
        logic [5:0] vertex_b;
        logic       from_start;
        logic [6:0] degree_query;
    } in_item_t;

    typedef struct packed {
        logic       found;
        logic [5:0] vertex_out;
        logic [6:0] count_out;
    } out_item_t;

    typedef struct packed {
        op_t        op;
        logic [5:0] vertex_a;
        logic [5:0] vertex_b;
        logic       from_start;
        logic [6:0] degree_query;
        logic [6:0] n;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_out_t;

endpackage

`default_nettype wire

// ----- sv/amds_front.sv -----
// ----------------------------------------------------------------------------
// amds_front
// accepts requests, range checks and classifies them, queues commands
// ----------------------------------------------------------------------------
`default_nettype none

module amds_front
    import amds_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_data,
    input  wire logic [6:0] vertex_count,
    output queue_out_t      q_out,
    input  wire logic       q_pop
);

    cmd_t       cmd;
    logic [6:0] n;
    logic       a_ok;
    logic       b_ok;
    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    always_comb begin
        if (32'(vertex_count) > MAX_VERTICES) begin
            n = 7'(MAX_VERTICES);
        end else begin
            n = vertex_count;
        end
        a_ok = {1'b0, s_data.vertex_a} < n;
        b_ok = {1'b0, s_data.vertex_b} < n;
        cmd.vertex_a     = s_data.vertex_a;
        cmd.vertex_b     = s_data.vertex_b;
        cmd.from_start   = s_data.from_start;
        cmd.degree_query = s_data.degree_query;
        cmd.n            = n;
        unique case (mode_t'(s_data.mode))
            MODE_INSERT: cmd.op = (a_ok && b_ok) ? OP_INSERT : OP_NONE;
            MODE_REMOVE: cmd.op = (a_ok && b_ok) ? OP_REMOVE : OP_NONE;
            MODE_TEST:   cmd.op = (a_ok && b_ok) ? OP_TEST : OP_NONE;
            MODE_NEXT:   cmd.op = a_ok ? OP_NEXT : OP_NONE;
            MODE_COUNT:  cmd.op = (n != '0) ? OP_COUNT : OP_NONE;
            MODE_MAX:    cmd.op = (n != '0) ? OP_MAX : OP_NONE;
            MODE_MIN:    cmd.op = (n != '0) ? OP_MIN : OP_NONE;
            default:     cmd.op = OP_NONE;
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (q_pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cmd;
        end
    end

    assign q_out.valid = (cnt_reg != 2'd0);
    assign q_out.cmd   = fifo_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ----- sv/amds_back.sv -----
// ----------------------------------------------------------------------------
// amds_back
// executes commands against the adjacency rows and degree counters
// ----------------------------------------------------------------------------
`default_nettype none

module amds_back
    import amds_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire queue_out_t q_in,
    output logic            q_pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int DW = $clog2(MAX_VERTICES + 2);
    localparam int CW = (DW > 7) ? DW : 7;

    logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
    logic [DW-1:0]           deg_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] row_vld_reg;
    logic [MAX_VERTICES-1:0] deg_vld_reg;
    logic [MAX_VERTICES-1:0] row_rd_reg;
    logic                    row_rdv_reg;
    logic [DW-1:0]           deg_rd_reg;
    logic                    deg_rdv_reg;

    logic [MAX_VERTICES-1:0] row_q;
    logic [DW-1:0]           deg_q;
    logic [VW-1:0]           row_raddr, row_waddr, deg_raddr, deg_waddr;
    logic                    row_we, deg_we;
    logic [MAX_VERTICES-1:0] row_wdata;
    logic [DW-1:0]           deg_wdata;
    logic [DW-1:0]           delta;
    logic                    bit_b;
    logic                    is_ins;

    state_t     state_reg, state_next;
    cmd_t       cmd_reg, cmd_next;
    logic [6:0] idx_reg, idx_next;
    logic [6:0] pidx_reg, pidx_next;
    logic       pend_reg, pend_next;
    logic       have_reg, have_next;
    logic [DW-1:0] best_reg, best_next;
    logic [6:0] bidx_reg, bidx_next;
    logic [6:0] cnt_reg, cnt_next;
    out_item_t  out_reg, out_next;
    logic       out_valid_reg, out_valid_next;

    assign row_q = row_rdv_reg ? row_rd_reg : '0;
    assign deg_q = deg_rdv_reg ? deg_rd_reg : '0;

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        pidx_next      = pidx_reg;
        pend_next      = pend_reg;
        have_next      = have_reg;
        best_next      = best_reg;
        bidx_next      = bidx_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        q_pop          = 1'b0;
        row_raddr      = VW'(cmd_reg.vertex_a);
        deg_raddr      = VW'(cmd_reg.vertex_a);
        row_we         = 1'b0;
        row_waddr      = VW'(cmd_reg.vertex_a);
        row_wdata      = row_q;
        deg_we         = 1'b0;
        deg_waddr      = VW'(cmd_reg.vertex_a);
        is_ins         = (cmd_reg.op == OP_INSERT);
        delta          = (cmd_reg.vertex_a == cmd_reg.vertex_b) ? DW'(2) : DW'(1);
        deg_wdata      = is_ins ? deg_q + delta : deg_q - delta;
        bit_b          = row_q[VW'(cmd_reg.vertex_b)];

        unique case (state_reg)
            ST_IDLE: begin
                row_raddr = VW'(q_in.cmd.vertex_a);
                deg_raddr = VW'(q_in.cmd.vertex_a);
                if (q_in.valid && !out_valid_reg) begin
                    q_pop     = 1'b1;
                    cmd_next  = q_in.cmd;
                    idx_next  = '0;
                    pend_next = 1'b0;
                    have_next = 1'b0;
                    cnt_next  = '0;
                    case (q_in.cmd.op)
                        OP_NONE: begin
                            out_next       = '0;
                            out_valid_next = 1'b1;
                        end
                        OP_COUNT, OP_MAX, OP_MIN: state_next = ST_SCAN_DEG;
                        default: state_next = ST_CHECK;
                    endcase
                end
            end
            ST_CHECK: begin
                out_next = '0;
                case (cmd_reg.op)
                    OP_TEST: begin
                        out_next.found = bit_b;
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    OP_NEXT: begin
                        idx_next   = cmd_reg.from_start ? 7'd0
                                                        : {1'b0, cmd_reg.vertex_b} + 7'd1;
                        state_next = ST_SCAN_ROW;
                    end
                    default: begin
                        if (bit_b == is_ins) begin
                            out_valid_next = 1'b1;
                            state_next     = ST_IDLE;
                        end else begin
                            row_we                          = 1'b1;
                            row_wdata[VW'(cmd_reg.vertex_b)] = is_ins;
                            deg_we                          = 1'b1;
                            row_raddr                       = VW'(cmd_reg.vertex_b);
                            deg_raddr                       = VW'(cmd_reg.vertex_b);
                            if (cmd_reg.vertex_a == cmd_reg.vertex_b) begin
                                out_next.found = 1'b1;
                                out_valid_next = 1'b1;
                                state_next     = ST_IDLE;
                            end else begin
                                state_next = ST_WRITE_B;
                            end
                        end
                    end
                endcase
            end
            ST_WRITE_B: begin
                row_raddr                        = VW'(cmd_reg.vertex_b);
                deg_raddr                        = VW'(cmd_reg.vertex_b);
                row_we                           = 1'b1;
                row_waddr                        = VW'(cmd_reg.vertex_b);
                row_wdata[VW'(cmd_reg.vertex_a)] = is_ins;
                deg_we                           = 1'b1;
                deg_waddr                        = VW'(cmd_reg.vertex_b);
                deg_wdata                        = is_ins ? deg_q + DW'(1) : deg_q - DW'(1);
                out_next                         = '0;
                out_next.found                   = 1'b1;
                out_valid_next                   = 1'b1;
                state_next                       = ST_IDLE;
            end
            ST_SCAN_ROW: begin
                out_next = '0;
                if (idx_reg >= cmd_reg.n) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end else if (row_q[VW'(idx_reg)]) begin
                    out_next.found      = 1'b1;
                    out_next.vertex_out = 6'(idx_reg);
                    out_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end else begin
                    idx_next = idx_reg + 7'd1;
                end
            end
            ST_SCAN_DEG: begin
                deg_raddr = VW'(idx_reg);
                pend_next = 1'b0;
                if (idx_reg < cmd_reg.n) begin
                    idx_next  = idx_reg + 7'd1;
                    pidx_next = idx_reg;
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    case (cmd_reg.op)
                        OP_COUNT: begin
                            if (CW'(deg_q) == CW'(cmd_reg.degree_query)) begin
                                cnt_next = cnt_reg + 7'd1;
                            end
                        end
                        OP_MAX: begin
                            if (!have_reg || deg_q > best_reg) begin
                                have_next = 1'b1;
                                best_next = deg_q;
                                bidx_next = pidx_reg;
                            end
                        end
                        default: begin
                            if (!have_reg || deg_q < best_reg) begin
                                have_next = 1'b1;
                                best_next = deg_q;
                                bidx_next = pidx_reg;
                            end
                        end
                    endcase
                end else if (idx_reg >= cmd_reg.n) begin
                    out_next = '0;
                    if (cmd_reg.op == OP_COUNT) begin
                        out_next.found     = (cnt_reg != '0);
                        out_next.count_out = cnt_reg;
                    end else begin
                        out_next.found      = 1'b1;
                        out_next.vertex_out = 6'(bidx_reg);
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            row_vld_reg   <= '0;
            deg_vld_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            if (row_we) begin
                row_vld_reg[row_waddr] <= 1'b1;
            end
            if (deg_we) begin
                deg_vld_reg[deg_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        pidx_reg <= pidx_next;
        have_reg <= have_next;
        best_reg <= best_next;
        bidx_reg <= bidx_next;
        cnt_reg  <= cnt_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (row_we) begin
            adj_mem[row_waddr] <= row_wdata;
        end
        row_rd_reg  <= adj_mem[row_raddr];
        row_rdv_reg <= row_vld_reg[row_raddr];
    end

    always_ff @(posedge aclk) begin
        if (deg_we) begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        deg_rd_reg  <= deg_mem[deg_raddr];
        deg_rdv_reg <= deg_vld_reg[deg_raddr];
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ----- sv/adjacency_matrix_degree_store.sv -----
// ----------------------------------------------------------------------------
// adjacency_matrix_degree_store
// undirected graph as a symmetric bit matrix with per-vertex degree counters
//
//   port group   direction   transfer
//   s_*          in          one request (mode, vertices, query)
//   m_*          out         one result (found, vertex, count)
//   p*           in/out      register access, vertex_count at 0
//
// path from s_* transfer to m_valid: rejected request from idle, test edge via check
// insert/remove: via check, also write_b when two distinct rows and counters change
// next neighbor: via check, then a scan along the row register
// count/max/min: a degree scan, one degree counter read per cycle
// reset empties the graph at once through per-row and per-vertex valid bits
// a 2-entry command queue keeps s_ready high, until both entries fill, while a result waits on m_ready
// ----------------------------------------------------------------------------
`default_nettype none

module adjacency_matrix_degree_store
    import amds_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire in_item_t           s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output out_item_t               m_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [6:0] vertex_count_reg, vertex_count_next;
    queue_out_t q;
    logic       q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_VERTEX_COUNT) ? {25'd0, vertex_count_reg} : '0;

    always_comb begin
        vertex_count_next = vertex_count_reg;
        if (psel && penable && pwrite && (paddr == ADDR_VERTEX_COUNT)) begin
            vertex_count_next = pwdata[6:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= VERTEX_COUNT_RESET;
        end else begin
            vertex_count_reg <= vertex_count_next;
        end
    end

    amds_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .vertex_count(vertex_count_reg),
        .q_out       (q),
        .q_pop       (q_pop)
    );

    amds_back u_back (
        .aclk   (aclk),
        .aresetn(aresetn),
        .q_in   (q),
        .q_pop  (q_pop),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule

`default_nettype wire

// ----- sv/amds_checker.sv -----
// ----------------------------------------------------------------------------
// amds_checker
// port-level checks on the result channel and register port
// ----------------------------------------------------------------------------
`default_nettype none
`include "adjacency_matrix_degree_store_defines.svh"

module amds_checker
    import amds_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data,
    input wire logic      pready
);

    `AMDS_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped")
    `AMDS_ASSERT_IMP(a_vertex_needs_found, m_valid && (m_data.vertex_out != 6'd0), m_data.found, "vertex without found")
    `AMDS_ASSERT_IMP(a_count_needs_found, m_valid && (m_data.count_out != 7'd0), m_data.found, "count without found")
    `AMDS_ASSERT_IMP(a_pready_high, 1'b1, pready, "pready low")

endmodule

bind adjacency_matrix_degree_store amds_checker u_amds_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// testbench for the adjacency matrix degree store: random and directed graph
// requests are driven with valid/ready stalls, every result is checked
// against a local graph model kept in a small scoreboard class
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import amds_pkg::*;

    class graph_scoreboard;
        bit [63:0] rows [64];
        bit [6:0]  degree [64];
        bit [6:0]  vcount;
        out_item_t pending [$];
        int        errors;

        function void clear();
            for (int i = 0; i < 64; i++) begin
                rows[i] = '0;
                degree[i] = '0;
            end
            vcount = VERTEX_COUNT_RESET;
            pending.delete();
            errors = 0;
        endfunction

        function void note_request(in_item_t it);
            int n;
            int i;
            int best;
            out_item_t r;
            n = (vcount > 64) ? 64 : vcount;
            r = '0;
            case (mode_t'(it.mode))
                MODE_INSERT: begin
                    if (it.vertex_a < n && it.vertex_b < n && !rows[it.vertex_a][it.vertex_b]) begin
                        rows[it.vertex_a][it.vertex_b] = 1'b1;
                        rows[it.vertex_b][it.vertex_a] = 1'b1;
                        degree[it.vertex_a]++;
                        degree[it.vertex_b]++;
                        r.found = 1'b1;
                    end
                end
                MODE_REMOVE: begin
                    if (it.vertex_a < n && it.vertex_b < n && rows[it.vertex_a][it.vertex_b]) begin
                        rows[it.vertex_a][it.vertex_b] = 1'b0;
                        rows[it.vertex_b][it.vertex_a] = 1'b0;
                        degree[it.vertex_a]--;
                        degree[it.vertex_b]--;
                        r.found = 1'b1;
                    end
                end
                MODE_TEST: begin
                    if (it.vertex_a < n && it.vertex_b < n)
                        r.found = rows[it.vertex_a][it.vertex_b];
                end
                MODE_NEXT: begin
                    if (it.vertex_a < n) begin
                        for (i = it.from_start ? 0 : it.vertex_b + 1; i < n; i++) begin
                            if (rows[it.vertex_a][i]) begin
                                r.found = 1'b1;
                                r.vertex_out = i[5:0];
                                break;
                            end
                        end
                    end
                end
                MODE_COUNT: begin
                    for (i = 0; i < n; i++)
                        if (degree[i] == it.degree_query) r.count_out++;
                    r.found = (r.count_out != 0);
                end
                MODE_MAX, MODE_MIN: begin
                    if (n > 0) begin
                        best = 0;
                        for (i = 1; i < n; i++) begin
                            if (it.mode == MODE_MAX ? degree[i] > degree[best]
                                                    : degree[i] < degree[best])
                                best = i;
                        end
                        r.found = 1'b1;
                        r.vertex_out = best[5:0];
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.found !== want.found) begin
                $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
                errors++;
            end
            if (got.vertex_out !== want.vertex_out) begin
                $display("%0t: vertex_out expected %0d actual %0d", $time,
                         want.vertex_out, got.vertex_out);
                errors++;
            end
            if (got.count_out !== want.count_out) begin
                $display("%0t: count_out expected %0d actual %0d", $time,
                         want.count_out, got.count_out);
                errors++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_item_t s_data;
    logic m_valid;
    logic m_ready;
    out_item_t m_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    graph_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int cur_n;

    adjacency_matrix_degree_store u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    // result side: random stall, check on transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_request(in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(it);
        @(negedge aclk);
    endtask

    task automatic write_vertex_count(bit [6:0] value);
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        // wait out any request still in flight
        repeat (80) @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_VERTEX_COUNT;
        pwdata  <= {25'd0, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.vcount = value;
        cur_n = value;
    endtask

    function automatic in_item_t make_item(bit [2:0] mode, bit [5:0] a, bit [5:0] b,
                                           bit fs, bit [6:0] q);
        in_item_t it;
        it.mode = mode;
        it.vertex_a = a;
        it.vertex_b = b;
        it.from_start = fs;
        it.degree_query = q;
        return it;
    endfunction

    function automatic bit [5:0] pick_vertex();
        int lim;
        lim = (cur_n < 1) ? 1 : ((cur_n > 64) ? 64 : cur_n);
        if ($urandom_range(15) == 0) return 6'($urandom);
        return 6'($urandom_range(lim - 1));
    endfunction

    function automatic in_item_t rand_item();
        int r;
        bit [2:0] mode;
        r = $urandom_range(99);
        if (r < 35) mode = MODE_INSERT;
        else if (r < 50) mode = MODE_REMOVE;
        else if (r < 62) mode = MODE_TEST;
        else if (r < 80) mode = MODE_NEXT;
        else if (r < 88) mode = MODE_COUNT;
        else if (r < 93) mode = MODE_MAX;
        else if (r < 98) mode = MODE_MIN;
        else mode = MODE_UNUSED;
        return make_item(mode, pick_vertex(), pick_vertex(), 1'($urandom),
                         ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(8)));
    endfunction

    task automatic random_phase(int count);
        for (int k = 0; k < count; k++) send_request(rand_item());
    endtask

    initial begin
        int wait_cycles;
        sb = new();
        sb.clear();
        cur_n = VERTEX_COUNT_RESET;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 13;
        recv_idle_pct = 83;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extremes, self loop, every mode, out of range
        send_request(make_item(MODE_MAX, 0, 0, 0, 0));
        send_request(make_item(MODE_MIN, 0, 0, 0, 0));
        send_request(make_item(MODE_COUNT, 0, 0, 0, 7'd0));
        send_request(make_item(MODE_INSERT, 6'd0, 6'd63, 0, 0));
        send_request(make_item(MODE_INSERT, 6'd63, 6'd0, 0, 0));
        send_request(make_item(MODE_INSERT, 6'd5, 6'd5, 0, 0));
        send_request(make_item(MODE_TEST, 6'd63, 6'd0, 0, 0));
        send_request(make_item(MODE_NEXT, 6'd0, 6'd0, 1, 0));
        send_request(make_item(MODE_NEXT, 6'd0, 6'd62, 0, 0));
        send_request(make_item(MODE_NEXT, 6'd0, 6'd63, 0, 0));
        send_request(make_item(MODE_COUNT, 0, 0, 0, 7'd2));
        send_request(make_item(MODE_COUNT, 0, 0, 0, 7'd127));
        send_request(make_item(MODE_MAX, 0, 0, 0, 0));
        send_request(make_item(MODE_MIN, 0, 0, 0, 0));
        send_request(make_item(MODE_UNUSED, 6'd63, 6'd63, 1, 7'd127));
        send_request(make_item(MODE_REMOVE, 6'd5, 6'd5, 0, 0));
        send_request(make_item(MODE_REMOVE, 6'd5, 6'd5, 0, 0));
        write_vertex_count(7'd10);
        send_request(make_item(MODE_INSERT, 6'd10, 6'd1, 0, 0));
        send_request(make_item(MODE_TEST, 6'd0, 6'd63, 0, 0));
        send_request(make_item(MODE_NEXT, 6'd0, 6'd0, 1, 0));
        send_request(make_item(MODE_REMOVE, 6'd63, 6'd0, 0, 0));
        write_vertex_count(7'd0);
        send_request(make_item(MODE_MAX, 0, 0, 0, 0));
        send_request(make_item(MODE_COUNT, 0, 0, 0, 7'd0));
        write_vertex_count(7'd127);
        send_request(make_item(MODE_REMOVE, 6'd63, 6'd0, 0, 0));

        write_vertex_count(7'd8);
        random_phase(250);
        write_vertex_count(7'd1);
        random_phase(60);
        send_idle_pct = 83;
        recv_idle_pct = 13;
        write_vertex_count(7'd64);
        random_phase(350);
        write_vertex_count(7'd3);
        random_phase(80);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_vertex_count(7'd100);
        random_phase(400);
        write_vertex_count(7'd16);
        random_phase(250);
        write_vertex_count(7'd64);
        random_phase(260);
        s_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 200000) begin
            @(negedge aclk);
            wait_cycles++;
        end
        repeat (100) @(negedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+sv
sv/amds_pkg.sv
sv/amds_front.sv
sv/amds_back.sv
sv/adjacency_matrix_degree_store.sv
sv/amds_checker.sv
tb/sv/tb_top.sv
